// ----- src/assert_macros.svh -----
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lswc_pkg.sv -----
`timescale 1ns / 1ps
package lswc_pkg;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF = 4;
  localparam int CLIP_PASSES = 4;
  localparam int CFG_ADDR_WIDTH = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [3:0] OC_LEFT = 4'h1;
  localparam logic [3:0] OC_RIGHT = 4'h2;
  localparam logic [3:0] OC_BOTTOM = 4'h4;
  localparam logic [3:0] OC_TOP = 4'h8;

  localparam logic [1:0] REG_X_MIN = 2'd0;
  localparam logic [1:0] REG_Y_MIN = 2'd1;
  localparam logic [1:0] REG_X_MAX = 2'd2;
  localparam logic [1:0] REG_Y_MAX = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } clip_state_t;
endpackage

// ----- src/lswc_if.sv -----
`timescale 1ns / 1ps
interface lswc_if #(parameter int W = 64) ();
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/line_segment_window_clipper_unit.sv -----
`timescale 1ns / 1ps
// each clip pass runs one shift-subtract divider, one quotient bit per cycle, and
// a new segment leaves the queue only once the last one is done; a two-entry queue
// in front lets inputs be taken while a segment is clipped
// reset: synchronous active-low rst_n clears control, window to 0..1.0
module line_segment_window_clipper_unit #(
  parameter int COORD_WIDTH = lswc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS = lswc_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  lswc_if.sink   in_ch,
  lswc_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [lswc_pkg::CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic signed [COORD_WIDTH-1:0] xl, yl, xh, yh;
  logic q_valid, q_ready;
  logic [4*COORD_WIDTH-1:0] q_data;

  assign pready = 1'b1;

  lswc_cfg #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .xl, .yl, .xh, .yh
  );

  lswc_front #(.CW(COORD_WIDTH)) u_front (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_data(in_ch.data), .q_valid, .q_ready, .q_data
  );

  lswc_back #(.CW(COORD_WIDTH)) u_back (
    .clk, .rst_n, .xl, .yl, .xh, .yh, .q_valid, .q_ready, .q_data,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule

// ----- src/lswc_front.sv -----
`timescale 1ns / 1ps
module lswc_front #(
  parameter int CW = lswc_pkg::COORD_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [4*CW-1:0]  in_data,
  output logic             q_valid,
  input  logic             q_ready,
  output logic [4*CW-1:0]  q_data
);
  localparam int D = lswc_pkg::QUEUE_DEPTH;
  logic [4*CW-1:0] mem_r [D];
  logic [$clog2(D)-1:0] wp_r, rp_r;
  logic [$clog2(D):0] cnt_r;
  logic push, pop;

  assign in_ready = (cnt_r != D[$clog2(D):0]);
  assign q_valid = (cnt_r != '0);
  assign q_data = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{$clog2(D){1'b0}}, push} - {{$clog2(D){1'b0}}, pop};
    end
  end
endmodule

// ----- src/lswc_div.sv -----
`timescale 1ns / 1ps
module lswc_div #(
  parameter int NW = 48,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CNTW = $clog2(NW + 1);
  logic [NW-1:0] q_r;
  logic [DW:0] rem_r;
  logic [CNTW-1:0] cnt_r;
  logic busy_r;
  logic [DW:0] sh;
  logic ge;

  assign sh = {rem_r[DW-1:0], q_r[NW-1]};
  assign ge = (sh >= {1'b0, den});
  assign quo = q_r;
  assign done = busy_r && (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= num;
      rem_r <= '0;
    end else if (busy_r && cnt_r != '0) begin
      rem_r <= ge ? sh - {1'b0, den} : sh;
      q_r <= {q_r[NW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= CNTW'(NW);
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end
endmodule

// ----- src/lswc_back.sv -----
`timescale 1ns / 1ps
module lswc_back #(
  parameter int CW = lswc_pkg::COORD_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic signed [CW-1:0] xl,
  input  logic signed [CW-1:0] yl,
  input  logic signed [CW-1:0] xh,
  input  logic signed [CW-1:0] yh,
  input  logic             q_valid,
  output logic             q_ready,
  input  logic [4*CW-1:0]  q_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [4*CW:0]    out_data
);
  localparam int DW = CW + 1;
  localparam int NW = 2 * DW;
  localparam int PW = $clog2(lswc_pkg::CLIP_PASSES + 1);

  lswc_pkg::clip_state_t st_r, st_nxt;
  logic signed [CW-1:0] px_r [2];
  logic signed [CW-1:0] py_r [2];
  logic [PW-1:0] pass_r;
  logic k_r, vert_r, neg_r;
  logic signed [CW-1:0] e_r;
  logic [NW-1:0] prod_r;
  logic [DW-1:0] den_r;
  logic vis_r;
  logic [4*CW:0] res_r;
  logic ov_r;

  logic [3:0] c0, c1, c;
  logic k;
  logic signed [DW-1:0] da, db, dd;
  logic [DW-1:0] ma, mb, md;
  logic div_start, div_done;
  logic [NW-1:0] quo;
  logic signed [NW+1:0] qs, sum;
  logic signed [CW-1:0] sat, base;
  logic signed [CW-1:0] maxv, minv;

  function automatic logic [3:0] ocode(input logic signed [CW-1:0] x, y,
                                       input logic signed [CW-1:0] a, b, p, r);
    logic [3:0] o;
    o = '0;
    if (x < a) o |= lswc_pkg::OC_LEFT;
    if (x > p) o |= lswc_pkg::OC_RIGHT;
    if (y < b) o |= lswc_pkg::OC_BOTTOM;
    if (y > r) o |= lswc_pkg::OC_TOP;
    return o;
  endfunction

  assign c0 = ocode(px_r[0], py_r[0], xl, yl, xh, yh);
  assign c1 = ocode(px_r[1], py_r[1], xl, yl, xh, yh);
  assign k = (c0 == '0);
  assign c = k ? c1 : c0;
  assign maxv = {1'b0, {(CW-1){1'b1}}};
  assign minv = {1'b1, {(CW-1){1'b0}}};

  always_comb begin
    logic signed [CW-1:0] ee;
    if ((c & (lswc_pkg::OC_LEFT | lswc_pkg::OC_RIGHT)) != '0) begin
      ee = ((c & lswc_pkg::OC_LEFT) != '0) ? xl : xh;
      da = DW'(py_r[!k]) - DW'(py_r[k]);
      db = DW'(ee) - DW'(px_r[k]);
      dd = DW'(px_r[!k]) - DW'(px_r[k]);
    end else begin
      ee = ((c & lswc_pkg::OC_BOTTOM) != '0) ? yl : yh;
      da = DW'(px_r[!k]) - DW'(px_r[k]);
      db = DW'(ee) - DW'(py_r[k]);
      dd = DW'(py_r[!k]) - DW'(py_r[k]);
    end
  end

  assign ma = da[DW-1] ? -da : da;
  assign mb = db[DW-1] ? -db : db;
  assign md = dd[DW-1] ? -dd : dd;

  lswc_div #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(prod_r), .den(den_r),
    .done(div_done), .quo(quo)
  );

  assign base = vert_r ? py_r[k_r] : px_r[k_r];
  assign qs = (den_r == '0) ? '0 :
              (neg_r ? -$signed({2'b00, quo}) : $signed({2'b00, quo}));
  assign sum = qs + (NW+2)'(base);
  assign sat = (sum > (NW+2)'(maxv)) ? maxv :
               (sum < (NW+2)'(minv)) ? minv : sum[CW-1:0];

  assign q_ready = (st_r == lswc_pkg::ST_IDLE);
  assign out_valid = ov_r;
  assign out_data = res_r;

  always_comb begin
    st_nxt = st_r;
    div_start = 1'b0;
    unique case (st_r)
      lswc_pkg::ST_IDLE: if (q_valid) st_nxt = lswc_pkg::ST_TEST;
      lswc_pkg::ST_TEST: begin
        if ((c0 | c1) == '0 || (c0 & c1) != '0 ||
            pass_r == PW'(lswc_pkg::CLIP_PASSES)) st_nxt = lswc_pkg::ST_DONE;
        else st_nxt = lswc_pkg::ST_MUL;
      end
      lswc_pkg::ST_MUL: begin
        div_start = 1'b1;
        st_nxt = lswc_pkg::ST_DIV;
      end
      lswc_pkg::ST_DIV: if (div_done) st_nxt = lswc_pkg::ST_FIX;
      lswc_pkg::ST_FIX: st_nxt = lswc_pkg::ST_TEST;
      lswc_pkg::ST_DONE: if (!ov_r) st_nxt = lswc_pkg::ST_IDLE;
      default: st_nxt = lswc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= lswc_pkg::ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      else if (st_r == lswc_pkg::ST_DONE && !ov_r) ov_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      lswc_pkg::ST_IDLE: begin
        px_r[0] <= q_data[CW-1:0];
        py_r[0] <= q_data[2*CW-1:CW];
        px_r[1] <= q_data[3*CW-1:2*CW];
        py_r[1] <= q_data[4*CW-1:3*CW];
        pass_r <= '0;
      end
      lswc_pkg::ST_TEST: begin
        vis_r <= ((c0 | c1) == '0);
        k_r <= k;
        vert_r <= (c & (lswc_pkg::OC_LEFT | lswc_pkg::OC_RIGHT)) != '0;
        e_r <= ((c & lswc_pkg::OC_LEFT) != '0) ? xl :
               ((c & lswc_pkg::OC_RIGHT) != '0) ? xh :
               ((c & lswc_pkg::OC_BOTTOM) != '0) ? yl : yh;
        prod_r <= NW'(ma) * NW'(mb);
        den_r <= md;
        neg_r <= (da[DW-1] ^ db[DW-1]) ^ dd[DW-1];
      end
      lswc_pkg::ST_FIX: begin
        pass_r <= pass_r + 1'b1;
        if (vert_r) begin
          py_r[k_r] <= sat;
          px_r[k_r] <= e_r;
        end else begin
          px_r[k_r] <= sat;
          py_r[k_r] <= e_r;
        end
      end
      lswc_pkg::ST_DONE: begin
        if (!ov_r) res_r <= vis_r ? {py_r[1], px_r[1], py_r[0], px_r[0], 1'b1}
                                  : '0;
      end
      default: ;
    endcase
  end
endmodule

// ----- src/lswc_cfg.sv -----
`timescale 1ns / 1ps
module lswc_cfg #(
  parameter int CW = lswc_pkg::COORD_WIDTH_DEF,
  parameter int FB = lswc_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [lswc_pkg::CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic signed [CW-1:0] xl,
  output logic signed [CW-1:0] yl,
  output logic signed [CW-1:0] xh,
  output logic signed [CW-1:0] yh
);
  logic signed [CW-1:0] xl_r, yl_r, xh_r, yh_r;
  logic [1:0] idx;
  assign idx = paddr[3:2];
  assign xl = xl_r;
  assign yl = yl_r;
  assign xh = xh_r;
  assign yh = yh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xl_r <= '0;
      yl_r <= '0;
      xh_r <= CW'(1 << FB);
      yh_r <= CW'(1 << FB);
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        lswc_pkg::REG_X_MIN: xl_r <= pwdata[CW-1:0];
        lswc_pkg::REG_Y_MIN: yl_r <= pwdata[CW-1:0];
        lswc_pkg::REG_X_MAX: xh_r <= pwdata[CW-1:0];
        lswc_pkg::REG_Y_MAX: yh_r <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lswc_pkg::REG_X_MIN: prdata = 32'($unsigned(xl_r));
      lswc_pkg::REG_Y_MIN: prdata = 32'($unsigned(yl_r));
      lswc_pkg::REG_X_MAX: prdata = 32'($unsigned(xh_r));
      lswc_pkg::REG_Y_MAX: prdata = 32'($unsigned(yh_r));
      default: prdata = '0;
    endcase
  end
endmodule

// ----- src/lswc_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lswc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [64:0] out_data
);
  `ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid, "input dropped")
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "output dropped")
  `ASSERT_NEXT(a_data_hold, clk, rst_n, out_valid && !out_ready, $stable(out_data), "data moved")
  `ASSERT_IMPL(a_reject_zero, clk, rst_n, out_valid && !out_data[0], out_data[64:1] == '0, "rejected not zero")
  `ASSERT_NEXT(a_no_back_out, clk, rst_n, out_valid && out_ready, !out_valid, "repeat result")
endmodule

bind line_segment_window_clipper_unit lswc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  typedef struct packed {
    logic signed [15:0] end_y;
    logic signed [15:0] end_x;
    logic signed [15:0] start_y;
    logic signed [15:0] start_x;
  } segment_t;

  typedef struct packed {
    logic signed [15:0] clip_end_y;
    logic signed [15:0] clip_end_x;
    logic signed [15:0] clip_start_y;
    logic signed [15:0] clip_start_x;
    logic visible;
  } clipped_t;

  typedef struct {
    segment_t seg;
    bit known;
    clipped_t res;
  } row_t;

  localparam longint COORD_MAX = 32767;
  localparam longint COORD_MIN = -32768;
  localparam longint CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [lswc_pkg::CFG_ADDR_WIDTH-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  lswc_if #(.W($bits(segment_t))) in_ch ();
  lswc_if #(.W($bits(clipped_t))) out_ch ();

  line_segment_window_clipper_unit uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic signed [15:0] win_xl = 16'sd0;
  logic signed [15:0] win_yl = 16'sd0;
  logic signed [15:0] win_xh = 16'sd16;
  logic signed [15:0] win_yh = 16'sd16;

  clipped_t pending_clips[$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  longint cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint sat16(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic logic [3:0] region_code(longint x, longint y);
    logic [3:0] c;
    c = '0;
    if (x < win_xl) c |= lswc_pkg::OC_LEFT;
    if (x > win_xh) c |= lswc_pkg::OC_RIGHT;
    if (y < win_yl) c |= lswc_pkg::OC_BOTTOM;
    if (y > win_yh) c |= lswc_pkg::OC_TOP;
    return c;
  endfunction

  function automatic clipped_t clip_segment(segment_t s);
    longint px[2], py[2], e, d;
    logic [3:0] c0, c1, c;
    int k, o;
    bit vis;
    clipped_t r;
    px[0] = s.start_x; py[0] = s.start_y;
    px[1] = s.end_x; py[1] = s.end_y;
    vis = 0;
    for (int pass = 0; pass <= lswc_pkg::CLIP_PASSES; pass++) begin
      c0 = region_code(px[0], py[0]);
      c1 = region_code(px[1], py[1]);
      if ((c0 | c1) == 0) begin
        vis = 1;
        break;
      end
      if ((c0 & c1) != 0 || pass >= lswc_pkg::CLIP_PASSES) break;
      k = (c0 != 0) ? 0 : 1;
      o = 1 - k;
      c = k ? c1 : c0;
      if (c & (lswc_pkg::OC_LEFT | lswc_pkg::OC_RIGHT)) begin
        e = (c & lswc_pkg::OC_LEFT) ? longint'(win_xl) : longint'(win_xh);
        d = px[o] - px[k];
        py[k] = sat16(py[k] + ((d == 0) ? 0 : ((py[o] - py[k]) * (e - px[k])) / d));
        px[k] = e;
      end else begin
        e = (c & lswc_pkg::OC_BOTTOM) ? longint'(win_yl) : longint'(win_yh);
        d = py[o] - py[k];
        px[k] = sat16(px[k] + ((d == 0) ? 0 : ((px[o] - px[k]) * (e - py[k])) / d));
        py[k] = e;
      end
    end
    r = '0;
    r.visible = vis;
    if (vis) begin
      r.clip_start_x = 16'(px[0]); r.clip_start_y = 16'(py[0]);
      r.clip_end_x = 16'(px[1]); r.clip_end_y = 16'(py[1]);
    end
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // scoreboard: predict on input transaction, compare on output transaction
  always @(posedge clk) begin
    clipped_t got, want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) pending_clips.push_back(clip_segment(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (pending_clips.size() == 0) begin
          errors++;
          $display("%0t unexpected result transaction %h", $time, got);
        end else begin
          want = pending_clips.pop_front();
          check_field("visible", want.visible, got.visible);
          check_field("clip_start_x", want.clip_start_x, got.clip_start_x);
          check_field("clip_start_y", want.clip_start_y, got.clip_start_y);
          check_field("clip_end_x", want.clip_end_x, got.clip_end_x);
          check_field("clip_end_y", want.clip_end_y, got.clip_end_y);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic signed [15:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= lswc_pkg::CFG_ADDR_WIDTH'(idx) << 2;
    pwdata <= {{16{val[15]}}, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      lswc_pkg::REG_X_MIN: win_xl = val;
      lswc_pkg::REG_Y_MIN: win_yl = val;
      lswc_pkg::REG_X_MAX: win_xh = val;
      default: win_yh = val;
    endcase
  endtask

  task automatic set_window(int xl, int yl, int xh, int yh);
    write_reg(lswc_pkg::REG_X_MIN, 16'(xl));
    write_reg(lswc_pkg::REG_Y_MIN, 16'(yl));
    write_reg(lswc_pkg::REG_X_MAX, 16'(xh));
    write_reg(lswc_pkg::REG_Y_MAX, 16'(yh));
  endtask

  task automatic drain();
    while (pending_clips.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic send_segment(segment_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= s;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic signed [15:0] coord_near(int lo, int hi);
    int span;
    span = hi - lo;
    if (span < 0) span = -span;
    span = span + 64;
    return 16'(sat16(longint'(lo) - span + $urandom_range(3 * span + hi - lo)));
  endfunction

  function automatic segment_t random_segment();
    segment_t s;
    int pick;
    pick = $urandom_range(9);
    if (pick < 3) begin
      s = {$urandom, $urandom};
    end else begin
      s.start_x = coord_near(win_xl, win_xh);
      s.start_y = coord_near(win_yl, win_yh);
      s.end_x = coord_near(win_xl, win_xh);
      s.end_y = coord_near(win_yl, win_yh);
      if (pick == 9) s.end_x = s.start_x;
      if (pick == 8) s.end_y = s.start_y;
    end
    return s;
  endfunction

  row_t directed[$];

  function automatic row_t mk(int sx, int sy, int ex, int ey, bit known = 0,
                              bit v = 0, int rsx = 0, int rsy = 0, int rex = 0,
                              int rey = 0);
    row_t r;
    r.seg.start_x = 16'(sx); r.seg.start_y = 16'(sy);
    r.seg.end_x = 16'(ex); r.seg.end_y = 16'(ey);
    r.known = known;
    r.res.visible = v;
    r.res.clip_start_x = 16'(rsx); r.res.clip_start_y = 16'(rsy);
    r.res.clip_end_x = 16'(rex); r.res.clip_end_y = 16'(rey);
    return r;
  endfunction

  initial begin
    int phase_idle[4] = '{0, 71, 0, 38};
    int phase_stall[4] = '{0, 0, 71, 38};
    directed = '{
      mk(0, 0, 16, 16, 1, 1, 0, 0, 16, 16),
      mk(-100, -100, -50, -50, 1, 0),
      mk(-32768, -32768, -32768, 32767, 1, 0),
      mk(32767, 32767, 32767, -32768, 1, 0),
      mk(-32768, 8, 32767, 8, 1, 1, 0, 8, 16, 8),
      mk(8, 32767, 8, -32768, 1, 1, 8, 16, 8, 0),
      mk(8, 8, 8, 8, 1, 1, 8, 8, 8, 8),
      mk(-8, 8, 8, 8),
      mk(8, -8, 8, 24),
      mk(-32768, -32768, 32767, 32767),
      mk(32767, -32768, -32768, 32767),
      mk(-10, 30, 30, -10),
      mk(-5, 20, 20, -5),
      mk(-1, 17, 17, -1),
      mk(24, 8, 8, 24),
      mk(-32768, 0, 0, 32767),
      mk(20, -3, 5, 40)
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      send_segment(directed[i].seg);
      if (directed[i].known && clip_segment(directed[i].seg) != directed[i].res) begin
        errors++;
        $display("%0t directed row %0d expected %h actual %h", $time, i,
                 directed[i].res, clip_segment(directed[i].seg));
      end
    end
    in_ch.valid <= 1'b0;
    drain();
    set_window(-32768, -32768, 32767, 32767);
    send_segment(mk(-32768, -32768, 32767, 32767).seg);
    send_segment(mk(1, 2, 3, 4).seg);
    in_ch.valid <= 1'b0;
    drain();
    set_window(100, 100, -100, -100);
    send_segment(mk(0, 0, 0, 0).seg);
    send_segment(mk(-200, 50, 200, -50).seg);
    in_ch.valid <= 1'b0;
    drain();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_window(-160, -80, 320, 240);
        1: set_window(-32768, 0, 32767, 16);
        2: set_window($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                      $urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
        default: set_window(-3000, -32768, 3000, 2000);
      endcase
      if (p == 2 && win_xl > win_xh) set_window(win_xh, win_yl, win_xl, win_yh);
      send_idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      for (int n = 0; n < 200; n++) begin
        if (p == 1 && n == 100) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (pending_clips.size() != 0) @(posedge clk);
        end
        send_segment(random_segment());
      end
      in_ch.valid <= 1'b0;
      stall_pct = phase_stall[p];
      drain();
    end
    stall_pct = 0;
    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+src
src/lswc_pkg.sv
src/lswc_if.sv
src/lswc_front.sv
src/lswc_div.sv
src/lswc_back.sv
src/lswc_cfg.sv
src/line_segment_window_clipper_unit.sv
src/lswc_checker.sv
dv/tb_top.sv
